// ===== sv/nlts_pkg.sv =====
`timescale 1ns / 1ps
// Shared widths, constants, register indexes and controller/datapath handshake
// types for the night light temperature scheduler. Depends on nothing.

package nlts_pkg;

   // Field and internal widths.
   localparam int TOD_W      = 17;  // seconds of day
   localparam int AUTO_W     = 18;  // signed automatic window bounds
   localparam int NIGHT_W    = 14;  // night temperature register
   localparam int TEMP_W     = 13;  // result temperature
   localparam int STATUS_W   = 2;
   localparam int SM_W       = 14;  // smear period and elapsed ramp time
   localparam int PROD_W     = 2 * SM_W;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 18;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 16;

   // Fixed scheduling constants.
   localparam int DAY_SECONDS    = 86400;
   localparam int MIN_NIGHT_TEMP = 1100;
   localparam int MIN_SMEAR      = 36;

   // Defaults for the top level parameters.
   localparam int SMEAR_SECONDS_DEF       = 3600;
   localparam int DEFAULT_TEMPERATURE_DEF = 6500;

   // Register reset values.
   localparam logic [TOD_W-1:0]   MANUAL_FROM_RST = 17'd72000;
   localparam logic [TOD_W-1:0]   MANUAL_TO_RST   = 17'd21600;
   localparam logic [NIGHT_W-1:0] NIGHT_RST       = 14'd4000;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_ENABLED     = 3'd0,
      CSR_ALL_DAY     = 3'd1,
      CSR_AUTOMATIC   = 3'd2,
      CSR_AUTO_FROM   = 3'd3,
      CSR_AUTO_TO     = 3'd4,
      CSR_MANUAL_FROM = 3'd5,
      CSR_MANUAL_TO   = 3'd6,
      CSR_NIGHT_TEMP  = 3'd7
   } csr_index_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_NEW       = 2'd0,
      STATUS_UNCHANGED = 2'd1,
      STATUS_INVALID   = 2'd2
   } status_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic load;       // capture the time of day
      logic win;        // pick the window and check the configuration
      logic smear;      // work out the smear period
      logic sel;        // classify the time against the window
      logic mul;        // form span times elapsed time
      logic div_start;  // launch the divider
      logic finish;     // write the result register and the last value
   } nlts_cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      logic ramp;
      logic div_busy;
      logic out_free;
   } nlts_sts_type;

endpackage

// ===== sv/nlts_div.sv =====
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, for the ramp interpolation.
// Depends on nlts_pkg.

module nlts_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [nlts_pkg::PROD_W-1:0] dividend,
   input  logic [nlts_pkg::SM_W-1:0]   divisor,
   output logic [nlts_pkg::SM_W-1:0]   quotient,
   output logic                      rem_nonzero,
   output logic                      busy
);
   import nlts_pkg::*;

   localparam int CNT_W = $clog2(PROD_W);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(PROD_W - 1);

   logic              busy_ff, busy_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [SM_W-1:0]   rem_ff, rem_in;
   logic [PROD_W-1:0] quo_ff, quo_in;
   logic [SM_W:0]     shifted;
   logic [SM_W+1:0]   trial;

   // The partial remainder stays below the divisor, so the shifted value is
   // below twice the divisor and one trial subtraction settles each bit.
   assign shifted = {rem_ff, quo_ff[PROD_W-1]};
   assign trial   = {1'b0, shifted} - {2'b00, divisor};

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = LAST_STEP;
         rem_in  = '0;
         quo_in  = dividend;
      end else if (busy_ff) begin
         if (trial[SM_W+1]) begin
            rem_in = shifted[SM_W-1:0];
            quo_in = {quo_ff[PROD_W-2:0], 1'b0};
         end else begin
            rem_in = trial[SM_W-1:0];
            quo_in = {quo_ff[PROD_W-2:0], 1'b1};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign quotient    = quo_ff[SM_W-1:0];
   assign rem_nonzero = |rem_ff;
   assign busy        = busy_ff;

endmodule

// ===== sv/nlts_dp.sv =====
`timescale 1ns / 1ps
// Scheduler datapath: configuration registers, window and smear arithmetic,
// ramp multiply and divide, last value and result register. Depends on
// nlts_pkg and nlts_div.

module nlts_dp #(
   parameter int SMEAR_SECONDS       = nlts_pkg::SMEAR_SECONDS_DEF,
   parameter int DEFAULT_TEMPERATURE = nlts_pkg::DEFAULT_TEMPERATURE_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [nlts_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [nlts_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic [nlts_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [nlts_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  nlts_pkg::nlts_cmd_type        cmd,
   output nlts_pkg::nlts_sts_type        sts
);
   import nlts_pkg::*;

   localparam int WIN_W = TOD_W + 2;
   localparam int PAD_W = RSP_DATA_W - TEMP_W - STATUS_W;

   localparam logic [NIGHT_W-1:0]      DFLT_T      = NIGHT_W'(DEFAULT_TEMPERATURE);
   localparam logic [SM_W-1:0]         SMEAR_T     = SM_W'(SMEAR_SECONDS);
   localparam logic [TOD_W-1:0]        DAY_T       = TOD_W'(DAY_SECONDS);
   localparam logic signed [WIN_W-1:0] DAY_S       = WIN_W'(DAY_SECONDS);
   localparam logic [NIGHT_W-1:0]      MIN_NIGHT_T = NIGHT_W'(MIN_NIGHT_TEMP);
   localparam logic [SM_W-1:0]         MIN_SMEAR_T = SM_W'(MIN_SMEAR);

   typedef enum logic [2:0] {
      MODE_INVALID,
      MODE_DEFAULT,
      MODE_NIGHT,
      MODE_FALL,
      MODE_RISE
   } mode_type;

   function automatic logic [TOD_W-1:0] fold_day(input logic [TOD_W-1:0] v);
      return (v >= DAY_T) ? v - DAY_T : v;
   endfunction

   function automatic logic bound_ok(input logic [AUTO_W-1:0] v);
      return !v[AUTO_W-1] && (v[TOD_W-1:0] < DAY_T);
   endfunction

   // Half-open window test with wrap past midnight.
   function automatic logic in_win(input logic signed [WIN_W-1:0] v,
                                   input logic signed [WIN_W-1:0] s,
                                   input logic signed [WIN_W-1:0] e);
      logic signed [WIN_W-1:0] ee;
      logic signed [WIN_W-1:0] vv;
      ee = e;
      vv = v;
      if (ee <= s) begin
         ee = ee + DAY_S;
      end
      if (vv < s && vv < ee) begin
         vv = vv + DAY_S;
      end
      return (vv >= s) && (vv < ee);
   endfunction

   function automatic logic [SM_W-1:0] wrap_elapsed(input logic signed [WIN_W-1:0] x);
      logic signed [WIN_W-1:0] r;
      r = x;
      if (r < 0) begin
         r = r + DAY_S;
      end else if (r >= DAY_S) begin
         r = r - DAY_S;
      end
      return r[SM_W-1:0];
   endfunction

   // Configuration registers. Manual bounds are stored already folded into
   // the day, which is how they are always used.
   logic               enabled_ff;
   logic               all_day_ff;
   logic               automatic_ff;
   logic [AUTO_W-1:0]  auto_from_ff;
   logic [AUTO_W-1:0]  auto_to_ff;
   logic [TOD_W-1:0]   manual_from_ff;
   logic [TOD_W-1:0]   manual_to_ff;
   logic [NIGHT_W-1:0] night_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff     <= 1'b0;
         all_day_ff     <= 1'b0;
         automatic_ff   <= 1'b0;
         auto_from_ff   <= '0;
         auto_to_ff     <= '0;
         manual_from_ff <= MANUAL_FROM_RST;
         manual_to_ff   <= MANUAL_TO_RST;
         night_ff       <= NIGHT_RST;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_addr))
            CSR_ENABLED:     enabled_ff     <= csr_wdata[0];
            CSR_ALL_DAY:     all_day_ff     <= csr_wdata[0];
            CSR_AUTOMATIC:   automatic_ff   <= csr_wdata[0];
            CSR_AUTO_FROM:   auto_from_ff   <= csr_wdata[AUTO_W-1:0];
            CSR_AUTO_TO:     auto_to_ff     <= csr_wdata[AUTO_W-1:0];
            CSR_MANUAL_FROM: manual_from_ff <= fold_day(csr_wdata[TOD_W-1:0]);
            CSR_MANUAL_TO:   manual_to_ff   <= fold_day(csr_wdata[TOD_W-1:0]);
            CSR_NIGHT_TEMP:  night_ff       <= csr_wdata[NIGHT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Working registers.
   logic [TOD_W-1:0]  t_ff;
   logic [TOD_W-1:0]  from_ff, from_in;
   logic [TOD_W-1:0]  to_ff, to_in;
   logic [TOD_W-1:0]  dist_ff, dist_in;
   logic              valid_ff, valid_in;
   logic [SM_W-1:0]   sm_ff, sm_in;
   mode_type          mode_ff, mode_in;
   logic [SM_W-1:0]   e_ff, e_in;
   logic [PROD_W-1:0] product_ff;
   logic [TEMP_W-1:0] last_ff;
   logic              rsp_tvalid_ff;
   logic [RSP_DATA_W-1:0] rsp_tdata_ff;

   // Window selection and configuration check.
   logic [TOD_W:0] fwd_diff;
   logic [TOD_W:0] bwd_diff;

   always_comb begin
      from_in  = automatic_ff ? auto_from_ff[TOD_W-1:0] : manual_from_ff;
      to_in    = automatic_ff ? auto_to_ff[TOD_W-1:0]   : manual_to_ff;
      fwd_diff = {1'b0, to_in} - {1'b0, from_in};
      bwd_diff = {1'b0, from_in} - {1'b0, to_in};
      dist_in  = fwd_diff[TOD_W] ? bwd_diff[TOD_W-1:0] : fwd_diff[TOD_W-1:0];
      valid_in = bound_ok(auto_from_ff) && bound_ok(auto_to_ff) &&
                 (night_ff >= MIN_NIGHT_T) && (night_ff <= DFLT_T);
   end

   // Smear period, shortened to the window length or its complement.
   logic [TOD_W-1:0] comp_w;
   logic [TOD_W-1:0] smear_w;

   always_comb begin
      comp_w  = DAY_T - dist_ff;
      smear_w = TOD_W'(SMEAR_T);
      if (dist_ff < smear_w) begin
         smear_w = dist_ff;
      end
      if (comp_w < smear_w) begin
         smear_w = comp_w;
      end
      sm_in = smear_w[SM_W-1:0];
   end

   // Classification of the time of day against the window and its ramps.
   logic signed [WIN_W-1:0] t_s, from_s, to_s, sm_s, fall_s, rise_s;

   always_comb begin
      t_s    = $signed(WIN_W'(t_ff));
      from_s = $signed(WIN_W'(from_ff));
      to_s   = $signed(WIN_W'(to_ff));
      sm_s   = $signed(WIN_W'(sm_ff));
      fall_s = from_s - sm_s;
      rise_s = to_s - sm_s;
      e_in   = wrap_elapsed(t_s - fall_s);
      if (!valid_ff) begin
         mode_in = MODE_INVALID;
      end else if (!enabled_ff) begin
         mode_in = MODE_DEFAULT;
      end else if (all_day_ff) begin
         mode_in = MODE_NIGHT;
      end else if (!in_win(t_s, fall_s, to_s)) begin
         mode_in = MODE_DEFAULT;
      end else if (sm_ff < MIN_SMEAR_T) begin
         mode_in = MODE_NIGHT;
      end else if (in_win(t_s, fall_s, from_s)) begin
         mode_in = MODE_FALL;
      end else if (in_win(t_s, rise_s, to_s)) begin
         mode_in = MODE_RISE;
         e_in    = wrap_elapsed(t_s - rise_s);
      end else begin
         mode_in = MODE_NIGHT;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         t_ff <= fold_day(req_tdata[TOD_W-1:0]);
      end
      if (cmd.win) begin
         from_ff  <= from_in;
         to_ff    <= to_in;
         dist_ff  <= dist_in;
         valid_ff <= valid_in;
      end
      if (cmd.smear) begin
         sm_ff <= sm_in;
      end
      if (cmd.sel) begin
         mode_ff <= mode_in;
         e_ff    <= e_in;
      end
      if (cmd.mul) begin
         product_ff <= PROD_W'(DFLT_T - night_ff) * PROD_W'(e_ff);
      end
   end

   // Ramp interpolation.
   logic [SM_W-1:0] quotient;
   logic            rem_nonzero;
   logic            div_busy;

   nlts_div u_div (
      .clock       (clock),
      .reset       (reset),
      .start       (cmd.div_start),
      .dividend    (product_ff),
      .divisor     (sm_ff),
      .quotient    (quotient),
      .rem_nonzero (rem_nonzero),
      .busy        (div_busy)
   );

   // Final temperature and status.
   logic [NIGHT_W-1:0] target_w;
   logic [TEMP_W-1:0]  result_w;
   status_type         status_w;

   always_comb begin
      case (mode_ff)
         MODE_DEFAULT: target_w = DFLT_T;
         MODE_NIGHT:   target_w = night_ff;
         MODE_FALL:    target_w = DFLT_T - (quotient + NIGHT_W'(rem_nonzero));
         MODE_RISE:    target_w = night_ff + quotient;
         default:      target_w = NIGHT_W'(last_ff);
      endcase
      result_w = target_w[TEMP_W-1:0];
      if (mode_ff == MODE_INVALID) begin
         status_w = STATUS_INVALID;
      end else if (result_w == last_ff) begin
         status_w = STATUS_UNCHANGED;
      end else begin
         status_w = STATUS_NEW;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff       <= DFLT_T[TEMP_W-1:0];
         rsp_tvalid_ff <= 1'b0;
      end else begin
         if (cmd.finish) begin
            rsp_tvalid_ff <= 1'b1;
            if (mode_ff != MODE_INVALID) begin
               last_ff <= result_w;
            end
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_tdata_ff <= {{PAD_W{1'b0}}, status_w, result_w};
      end
   end

   assign rsp_tvalid   = rsp_tvalid_ff;
   assign rsp_tdata    = rsp_tdata_ff;
   assign sts.ramp     = (mode_ff == MODE_FALL) || (mode_ff == MODE_RISE);
   assign sts.div_busy = div_busy;
   assign sts.out_free = !rsp_tvalid_ff || rsp_tready;

endmodule

// ===== sv/nlts_ctrl.sv =====
`timescale 1ns / 1ps
// Scheduler controller: sequences one tick through the datapath steps.
// Depends on nlts_pkg.

module nlts_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  nlts_pkg::nlts_sts_type sts,
   output nlts_pkg::nlts_cmd_type cmd
);
   import nlts_pkg::*;

   typedef enum logic [7:0] {
      S_IDLE  = 8'b0000_0001,
      S_WIN   = 8'b0000_0010,
      S_SMEAR = 8'b0000_0100,
      S_SEL   = 8'b0000_1000,
      S_MUL   = 8'b0001_0000,
      S_DLOAD = 8'b0010_0000,
      S_DIV   = 8'b0100_0000,
      S_OUT   = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_WIN;
            end
         end
         S_WIN: begin
            cmd.win  = 1'b1;
            state_in = S_SMEAR;
         end
         S_SMEAR: begin
            cmd.smear = 1'b1;
            state_in  = S_SEL;
         end
         S_SEL: begin
            cmd.sel  = 1'b1;
            state_in = S_MUL;
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = sts.ramp ? S_DLOAD : S_OUT;
         end
         S_DLOAD: begin
            cmd.div_start = 1'b1;
            state_in      = S_DIV;
         end
         S_DIV: begin
            if (!sts.div_busy) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (sts.out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== sv/night_light_temperature_scheduler_top.sv =====
`timescale 1ns / 1ps
// Top level of the night light color temperature scheduler.
// Depends on nlts_pkg, nlts_ctrl, nlts_dp (and through it nlts_div).

// The block takes one tick per transfer on the req_ channel, each carrying the
// time of day in seconds, and returns one transfer on the rsp_ channel with the
// color temperature in kelvin and a status code: new value, unchanged from the
// last applied value, or configuration invalid. Ticks are handled one at a
// time. A tick outside a ramp goes through the window, smear, select and
// multiply steps to the output register; a tick on the evening or morning ramp
// also goes through the restoring divider, one quotient bit per cycle over the
// 28-bit ramp product. The output register lets the next tick be accepted while
// an earlier result still waits on rsp_tready. The user must write registers
// through the csr_ port only while the block is idle; the block does not enforce
// it. Manual window bounds of 86400 or more are folded into the day when written.

module night_light_temperature_scheduler_top #(
   parameter int SMEAR_SECONDS       = nlts_pkg::SMEAR_SECONDS_DEF,
   parameter int DEFAULT_TEMPERATURE = nlts_pkg::DEFAULT_TEMPERATURE_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // Tick input.
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [nlts_pkg::REQ_DATA_W-1:0] req_tdata,  // [16:0] time_of_day
   // Result output.
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [nlts_pkg::RSP_DATA_W-1:0] rsp_tdata,  // [12:0] temperature, [14:13] status
   // Register writes.
   input  logic                          csr_we,
   input  logic [nlts_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [nlts_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import nlts_pkg::*;

   // Commands run from the controller to the datapath, status runs back.
   nlts_cmd_type cmd;
   nlts_sts_type sts;

   nlts_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // The datapath holds the registers, the window arithmetic, the ramp
   // multiply and divide, the last applied value and the output register.
   nlts_dp #(
      .SMEAR_SECONDS       (SMEAR_SECONDS),
      .DEFAULT_TEMPERATURE (DEFAULT_TEMPERATURE)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .sts        (sts)
   );

endmodule

// ===== sim/night_light_temperature_scheduler_top_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for night_light_temperature_scheduler_top: directed and
// random ticks are checked against a predictor of the schedule and its ramps.
// Depends on nlts_pkg and the scheduler RTL.

module night_light_temperature_scheduler_top_tb;
   import nlts_pkg::*;

   localparam int SMEAR_S = SMEAR_SECONDS_DEF;
   localparam int DFLT_K  = DEFAULT_TEMPERATURE_DEF;
   // Settling time for the slowest tick, which goes through the divider and the output register.
   localparam int SETTLE_CYCLES = 40;

   // Shadow copy of the register file as the predictor sees it.
   typedef struct {
      logic                     enabled;
      logic                     all_day;
      logic                     automatic_sel;
      logic signed [AUTO_W-1:0] auto_from;
      logic signed [AUTO_W-1:0] auto_to;
      logic [TOD_W-1:0]         manual_from;
      logic [TOD_W-1:0]         manual_to;
      logic [NIGHT_W-1:0]       night;
   } sched_cfg_type;

   typedef struct {
      logic [TEMP_W-1:0] temp;
      status_type        status;
   } sched_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   sched_cfg_type     cfg_now;
   logic [TEMP_W-1:0] last_applied;
   sched_result_type  temp_expect_q[$];
   sched_result_type  rsp_expect;
   int unsigned       mismatch_count = 0;

   // Sender burst control and receiver stall pattern state.
   int unsigned burst_left = 0;
   bit          gaps_on = 1'b1;
   int unsigned rx_cycle = 0;
   int unsigned rx_mode = 0;
   int unsigned rx_hold = 0;

   night_light_temperature_scheduler_top #(
      .SMEAR_SECONDS      (SMEAR_S),
      .DEFAULT_TEMPERATURE(DFLT_K)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Hard stop well beyond the slowest legal run.
   initial begin
      #20_000_000;
      $display("** night_light_temperature_scheduler_top: FAILED **");
      $finish;
   end

   // ------------------------------------------------------------------
   // Predictor. Times of day and manual bounds of 86400 or more are folded
   // once; the window test treats a start at or after the end as wrapping
   // past midnight.
   // ------------------------------------------------------------------
   function automatic longint fold_day(longint x);
      return (x >= DAY_SECONDS) ? x - DAY_SECONDS : x;
   endfunction

   function automatic longint wrap_day(longint x);
      longint r;
      r = x % DAY_SECONDS;
      if (r < 0) r += DAY_SECONDS;
      return r;
   endfunction

   function automatic bit in_window(longint v, longint s, longint e);
      if (e <= s) e += DAY_SECONDS;
      if (v < s && v < e) v += DAY_SECONDS;
      return (v >= s) && (v < e);
   endfunction

   // Works out the temperature for one tick and advances the last applied value.
   function automatic sched_result_type schedule_temperature(logic [TOD_W-1:0] tod);
      longint           t, af, at, night, target, from, to, d, sm, span, e;
      sched_result_type r;
      t     = fold_day(longint'(tod));
      af    = cfg_now.auto_from;
      at    = cfg_now.auto_to;
      night = longint'(cfg_now.night);
      if (af < 0 || af >= DAY_SECONDS || at < 0 || at >= DAY_SECONDS ||
          night < MIN_NIGHT_TEMP || night > DFLT_K) begin
         // A bad configuration reports the held value and leaves it alone.
         r.temp   = last_applied;
         r.status = STATUS_INVALID;
         return r;
      end
      if (!cfg_now.enabled) begin
         target = DFLT_K;
      end else if (cfg_now.all_day) begin
         target = night;
      end else begin
         from = cfg_now.automatic_sel ? af : fold_day(longint'(cfg_now.manual_from));
         to   = cfg_now.automatic_sel ? at : fold_day(longint'(cfg_now.manual_to));
         d    = to - from;
         if (d < 0) d = -d;
         // The smear period never exceeds the window or its complement.
         sm = SMEAR_S;
         if (d < sm) sm = d;
         if (DAY_SECONDS - d < sm) sm = DAY_SECONDS - d;
         span = DFLT_K - night;
         if (!in_window(t, from - sm, to)) begin
            target = DFLT_K;
         end else if (sm < MIN_SMEAR) begin
            target = night;
         end else if (in_window(t, from - sm, from)) begin
            e      = wrap_day(t - (from - sm));
            target = DFLT_K - (span * e + sm - 1) / sm;
         end else if (in_window(t, to - sm, to)) begin
            e      = wrap_day(t - (to - sm));
            target = night + (span * e) / sm;
         end else begin
            target = night;
         end
      end
      r.temp = target[TEMP_W-1:0];
      if (r.temp == last_applied) begin
         r.status = STATUS_UNCHANGED;
      end else begin
         r.status     = STATUS_NEW;
         last_applied = r.temp;
      end
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Result checker: every rsp_ transfer is matched against the oldest
   // expectation. Only the first ten failures are printed.
   // ------------------------------------------------------------------
   task automatic note_failure(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10) $display("%0t ns: %s", $time, msg);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (temp_expect_q.size() == 0) begin
            note_failure($sformatf("result with nothing expected: temperature %0d status %0d",
                                   rsp_tdata[12:0], rsp_tdata[14:13]));
         end else begin
            rsp_expect = temp_expect_q.pop_front();
            if (rsp_tdata[12:0] !== rsp_expect.temp)
               note_failure($sformatf("temperature: expected %0d, actual %0d",
                                      rsp_expect.temp, rsp_tdata[12:0]));
            if (rsp_tdata[14:13] !== rsp_expect.status)
               note_failure($sformatf("status: expected %0d, actual %0d",
                                      rsp_expect.status, rsp_tdata[14:13]));
         end
      end
   end

   // Receiver back-pressure. As rx_cycle counts, the pattern is redrawn at random from
   // always ready, coin-flip ready, and ready with occasional long stalls.
   always @(posedge clock) begin
      rx_cycle++;
      if (rx_cycle % 256 == 0) rx_mode = $urandom_range(0, 2);
      case (rx_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= 1'($urandom_range(0, 1));
         default: begin
            if (rx_hold != 0) begin
               rx_hold--;
               rsp_tready <= 1'b0;
            end else begin
               rsp_tready <= 1'b1;
               if ($urandom_range(0, 7) == 0) rx_hold = $urandom_range(1, 25);
            end
         end
      endcase
   end

   // ------------------------------------------------------------------
   // Stimulus helpers.
   // ------------------------------------------------------------------

   // Sends one tick and records its expected result at the accepting edge.
   // The valid is only lowered at the start of a gap, so back-to-back
   // transfers never see it dropped and raised in the same step.
   task automatic send_tick(input logic [TOD_W-1:0] tod);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = 0;
         if (gaps_on)
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 6);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_W'(tod);
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      temp_expect_q = {temp_expect_q, schedule_temperature(tod)};
   endtask

   // Holds the sender off until every expected result has come back.
   task automatic wait_drain();
      if (req_tvalid) req_tvalid <= 1'b0;
      burst_left = 0;
      while (temp_expect_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] val);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   // Writes the whole register file; called only with the block drained.
   task automatic configure(input sched_cfg_type c);
      wait_drain();
      write_reg(CSR_ENABLED,     CSR_DATA_W'(c.enabled));
      write_reg(CSR_ALL_DAY,     CSR_DATA_W'(c.all_day));
      write_reg(CSR_AUTOMATIC,   CSR_DATA_W'(c.automatic_sel));
      write_reg(CSR_AUTO_FROM,   CSR_DATA_W'(unsigned'(c.auto_from)));
      write_reg(CSR_AUTO_TO,     CSR_DATA_W'(unsigned'(c.auto_to)));
      write_reg(CSR_MANUAL_FROM, CSR_DATA_W'(c.manual_from));
      write_reg(CSR_MANUAL_TO,   CSR_DATA_W'(c.manual_to));
      write_reg(CSR_NIGHT_TEMP,  CSR_DATA_W'(c.night));
      csr_we  <= 1'b0;
      cfg_now = c;
   endtask

   // Window bound, often placed relative to another bound so that equal,
   // very short and nearly full-day windows all come up.
   function automatic longint pick_bound(longint base);
      case ($urandom_range(0, 5))
         0, 1: return $urandom_range(0, DAY_SECONDS - 1);
         2:    return base;
         3:    return wrap_day(base + longint'($urandom_range(0, 200)) - 100);
         4:    return $urandom_range(0, 1) ? 0 : DAY_SECONDS - 1;
         default: return wrap_day(base + longint'($urandom_range(0, 16000)) - 8000);
      endcase
   endfunction

   function automatic sched_cfg_type random_cfg();
      sched_cfg_type c;
      longint        b;
      c.enabled       = ($urandom_range(0, 99) < 88);
      c.all_day       = ($urandom_range(0, 99) < 10);
      c.automatic_sel = 1'($urandom_range(0, 1));
      b = $urandom_range(0, DAY_SECONDS - 1);
      c.auto_from = pick_bound(b);
      c.auto_to   = pick_bound(b);
      // Occasionally a raw 18-bit bound, which is mostly out of range.
      if ($urandom_range(0, 99) < 6) c.auto_from = $urandom_range(0, 262143);
      if ($urandom_range(0, 99) < 6) c.auto_to   = $urandom_range(0, 262143);
      c.manual_from = pick_bound(b);
      c.manual_to   = pick_bound(b);
      if ($urandom_range(0, 9) == 0) c.manual_from = $urandom_range(DAY_SECONDS, 131071);
      if ($urandom_range(0, 9) == 0) c.manual_to   = $urandom_range(DAY_SECONDS, 131071);
      case ($urandom_range(0, 19))
         0, 1:    c.night = $urandom_range(0, 1) ? MIN_NIGHT_TEMP : DFLT_K;
         2, 3, 4: c.night = $urandom_range(0, 16383);
         default: c.night = $urandom_range(MIN_NIGHT_TEMP, DFLT_K);
      endcase
      return c;
   endfunction

   // Tick time, mostly near an edge of the active window so that the ramps
   // are hit often.
   function automatic logic [TOD_W-1:0] pick_tick();
      longint anchor;
      if (cfg_now.automatic_sel)
         anchor = $urandom_range(0, 1) ? longint'(cfg_now.auto_from) : longint'(cfg_now.auto_to);
      else
         anchor = $urandom_range(0, 1) ? fold_day(longint'(cfg_now.manual_from))
                                       : fold_day(longint'(cfg_now.manual_to));
      anchor = wrap_day(anchor);
      case ($urandom_range(0, 19))
         0, 1, 2: return $urandom_range(0, DAY_SECONDS - 1);
         3, 4, 5: return $urandom_range(0, 131071);
         default: return TOD_W'(wrap_day(anchor + longint'($urandom_range(0, 4400)) - 4000));
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Tests.
   // ------------------------------------------------------------------

   // Reset values: disabled, so the default is reported as unchanged, even
   // for the largest time field.
   task automatic test_reset_state();
      send_tick(0);
      send_tick(131071);
   endtask

   task automatic test_disabled_and_all_day();
      sched_cfg_type c;
      c = cfg_now;
      c.enabled = 1'b1;
      c.all_day = 1'b1;
      c.night   = MIN_NIGHT_TEMP;
      configure(c);
      send_tick(12345);
      send_tick(86399);
      c.enabled = 1'b0;
      configure(c);
      send_tick(50000);
   endtask

   // Manual window across midnight with both ramps sampled at their ends
   // and middle, plus a tick of 86400 that folds to midnight.
   task automatic test_manual_ramps();
      sched_cfg_type c;
      c = cfg_now;
      c.enabled       = 1'b1;
      c.all_day       = 1'b0;
      c.automatic_sel = 1'b0;
      c.manual_from   = 72000;
      c.manual_to     = 21600;
      c.night         = 3000;
      configure(c);
      send_tick(68400);
      send_tick(70200);
      send_tick(72000);
      send_tick(18000);
      send_tick(19800);
      send_tick(21599);
      send_tick(21600);
      send_tick(86400);
   endtask

   task automatic test_special_windows();
      sched_cfg_type c;
      c = cfg_now;
      // Equal bounds cover the whole day with no ramp.
      c.automatic_sel = 1'b1;
      c.auto_from     = 43200;
      c.auto_to       = 43200;
      c.night         = DFLT_K;
      configure(c);
      send_tick(0);
      // A window shorter than the minimum smear gives no ramp at all.
      c.auto_from = 1000;
      c.auto_to   = 1020;
      c.night     = 2000;
      configure(c);
      send_tick(990);
      send_tick(1020);
      // Manual bounds past the end of the day are folded once.
      c.automatic_sel = 1'b0;
      c.manual_from   = 131071;
      c.manual_to     = DAY_SECONDS;
      configure(c);
      send_tick(42000);
      send_tick(86399);
   endtask

   // Any bad bound or night temperature is reported first, even when disabled.
   task automatic test_invalid_config();
      sched_cfg_type c, good;
      good = cfg_now;
      c = good;
      c.enabled   = 1'b0;
      c.auto_from = -DAY_SECONDS;
      configure(c);
      send_tick(100);
      c = good;
      c.auto_to = DAY_SECONDS;
      configure(c);
      send_tick(200);
      c = good;
      c.night = MIN_NIGHT_TEMP - 1;
      configure(c);
      send_tick(300);
      c.night = DFLT_K + 1;
      configure(c);
      send_tick(400);
      c.night = 16383;
      configure(c);
      send_tick(500);
      c.night = 0;
      configure(c);
      send_tick(600);
   endtask

   // Random phases, each with its own register setting and sender rhythm.
   // Somewhere in every phase the sender waits for all results to return.
   task automatic test_random_schedule();
      int unsigned pause_at;
      for (int phase = 0; phase < 14; phase++) begin
         configure(random_cfg());
         gaps_on  = ($urandom_range(0, 3) != 0);
         pause_at = $urandom_range(10, 40);
         for (int n = 0; n < 50; n++) begin
            if (n == pause_at) wait_drain();
            send_tick(pick_tick());
         end
      end
   endtask

   // ------------------------------------------------------------------
   // Main sequence.
   // ------------------------------------------------------------------
   initial begin
      cfg_now.enabled       = 1'b0;
      cfg_now.all_day       = 1'b0;
      cfg_now.automatic_sel = 1'b0;
      cfg_now.auto_from     = '0;
      cfg_now.auto_to       = '0;
      cfg_now.manual_from   = MANUAL_FROM_RST;
      cfg_now.manual_to     = MANUAL_TO_RST;
      cfg_now.night         = NIGHT_RST;
      last_applied          = TEMP_W'(DFLT_K);

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_state();
      test_disabled_and_all_day();
      test_manual_ramps();
      test_special_windows();
      test_invalid_config();
      test_random_schedule();

      // Let everything drain, then give stray results time to show up.
      wait_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && temp_expect_q.size() == 0) begin
         $display("** night_light_temperature_scheduler_top: PASSED **");
      end else begin
         $display("** night_light_temperature_scheduler_top: FAILED **");
      end
      $finish;
   end

endmodule
